// ----- hw/rtl/ppna_pkg.sv -----
// ppna_pkg: shared codes and types of the ppp negotiation automaton
// event codes, automaton states, layer notices and the result word layout
// no dependencies; imported by the channel interfaces and the top level
package ppna_pkg;

  // field widths
  localparam int unsigned OpW     = 4;
  localparam int unsigned IdW     = 8;
  localparam int unsigned StateW  = 4;
  localparam int unsigned NoticeW = 3;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // event codes
  localparam logic [OpW-1:0] OP_LOWER_UP   = 4'd0;
  localparam logic [OpW-1:0] OP_LOWER_DOWN = 4'd1;
  localparam logic [OpW-1:0] OP_OPEN       = 4'd2;
  localparam logic [OpW-1:0] OP_CLOSE      = 4'd3;
  localparam logic [OpW-1:0] OP_RCR_GOOD   = 4'd4;
  localparam logic [OpW-1:0] OP_RCR_NAK    = 4'd5;
  localparam logic [OpW-1:0] OP_RCR_REJ    = 4'd6;
  localparam logic [OpW-1:0] OP_RCA        = 4'd7;
  localparam logic [OpW-1:0] OP_RCN        = 4'd8;
  localparam logic [OpW-1:0] OP_RTR        = 4'd9;
  localparam logic [OpW-1:0] OP_RTA        = 4'd10;
  localparam logic [OpW-1:0] OP_RUC        = 4'd11;
  localparam logic [OpW-1:0] OP_RXJ_PERM   = 4'd12;
  localparam logic [OpW-1:0] OP_RXJ_BAD    = 4'd13;
  localparam logic [OpW-1:0] OP_TICK       = 4'd14;

  // automaton states
  localparam logic [StateW-1:0] ST_INITIAL  = 4'd0;
  localparam logic [StateW-1:0] ST_STARTING = 4'd1;
  localparam logic [StateW-1:0] ST_CLOSED   = 4'd2;
  localparam logic [StateW-1:0] ST_STOPPED  = 4'd3;
  localparam logic [StateW-1:0] ST_CLOSING  = 4'd4;
  localparam logic [StateW-1:0] ST_STOPPING = 4'd5;
  localparam logic [StateW-1:0] ST_REQ_SENT = 4'd6;
  localparam logic [StateW-1:0] ST_ACK_RCVD = 4'd7;
  localparam logic [StateW-1:0] ST_ACK_SENT = 4'd8;
  localparam logic [StateW-1:0] ST_OPENED   = 4'd9;

  // layer notices
  localparam logic [NoticeW-1:0] N_NONE     = 3'd0;
  localparam logic [NoticeW-1:0] N_UP       = 3'd1;
  localparam logic [NoticeW-1:0] N_DOWN     = 3'd2;
  localparam logic [NoticeW-1:0] N_STARTED  = 3'd3;
  localparam logic [NoticeW-1:0] N_FINISHED = 3'd4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_RESTART_PERIOD = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TERMINATE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_CONFIGURE  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_FAILURE    = 2'd3;

  // configuration reset values
  localparam logic [PeriodW-1:0] RESTART_PERIOD_RST = 16'd3000;
  localparam logic [CountW-1:0]  MAX_TERMINATE_RST  = 8'd2;
  localparam logic [CountW-1:0]  MAX_CONFIGURE_RST  = 8'd10;
  localparam logic [CountW-1:0]  MAX_FAILURE_RST    = 8'd5;

  // one result word
  typedef struct packed {
    logic [StateW-1:0]  new_state;
    logic [NoticeW-1:0] layer_notice;
    logic               emit_conf_request;
    logic               emit_conf_ack;
    logic               emit_conf_nak;
    logic               emit_conf_reject;
    logic               emit_term_request;
    logic               emit_term_ack;
    logic [IdW-1:0]     term_request_id;
    logic [IdW-1:0]     term_ack_id;
  } ppna_res_t;

endpackage

// ----- hw/rtl/ppna_in_if.sv -----
// ppna_in_if: event channel of the ppp negotiation automaton
// valid/ready handshake carrying one event word; uses ppna_pkg
interface ppna_in_if import ppna_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [OpW-1:0] op;
  logic [IdW-1:0] received_id;

  modport source (output valid, output op, output received_id, input ready);
  modport sink (input valid, input op, input received_id, output ready);
endinterface

// ----- hw/rtl/ppna_out_if.sv -----
// ppna_out_if: result channel of the ppp negotiation automaton
// valid/ready handshake carrying one result word; uses ppna_pkg
interface ppna_out_if import ppna_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StateW-1:0]  new_state;
  logic [NoticeW-1:0] layer_notice;
  logic               emit_conf_request;
  logic               emit_conf_ack;
  logic               emit_conf_nak;
  logic               emit_conf_reject;
  logic               emit_term_request;
  logic               emit_term_ack;
  logic [IdW-1:0]     term_request_id;
  logic [IdW-1:0]     term_ack_id;

  modport source (
    output valid, output new_state, output layer_notice,
    output emit_conf_request, output emit_conf_ack, output emit_conf_nak,
    output emit_conf_reject, output emit_term_request, output emit_term_ack,
    output term_request_id, output term_ack_id, input ready
  );
  modport sink (
    input valid, input new_state, input layer_notice,
    input emit_conf_request, input emit_conf_ack, input emit_conf_nak,
    input emit_conf_reject, input emit_term_request, input emit_term_ack,
    input term_request_id, input term_ack_id, output ready
  );
endinterface

// ----- hw/rtl/ppna_top.sv -----
// PPP option negotiation automaton: one event per word in, one result word out.
// Each accepted event is decoded against the current automaton state, restart
// counter and restart timer; the next state and the result word are written
// together at the accepting edge, so an event may be accepted on every clock
// cycle while the result register is free or being taken. The single output
// register is refilled in the same cycle it is taken, so input ready follows
// output ready while a result is waiting. Tick events drive the restart timer;
// configuration writes take effect for the next event and are meant to be
// done while no result is pending. No clearing pass is needed after reset.
// depends on ppna_pkg, ppna_in_if, ppna_out_if
module ppp_negotiation_automaton_top import ppna_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  ppna_in_if.sink            in_i,
  ppna_out_if.source         out_o
);

  // configuration registers
  logic [PeriodW-1:0] period_q;
  logic [CountW-1:0]  max_term_q, max_conf_q, max_fail_q;

  // automaton state
  logic [StateW-1:0]  state_q, state_d;
  logic [CountW-1:0]  retry_q, retry_d;
  logic [PeriodW-1:0] cnt_q, cnt_d;
  logic               run_q, run_d;
  logic [IdW-1:0]     req_id_q, req_id_d;

  // result register
  logic               out_vld_q;
  ppna_res_t          res_q, res_d;

  logic               accept;
  logic [StateW-1:0]  st;
  logic               do_irc, do_str, do_rcr;
  logic [CountW-1:0]  irc_n;

  assign in_i.ready = !out_vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= RESTART_PERIOD_RST;
      max_term_q <= MAX_TERMINATE_RST;
      max_conf_q <= MAX_CONFIGURE_RST;
      max_fail_q <= MAX_FAILURE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESTART_PERIOD: period_q   <= cfg_wdata_i;
        CFG_MAX_TERMINATE:  max_term_q <= cfg_wdata_i[CountW-1:0];
        CFG_MAX_CONFIGURE:  max_conf_q <= cfg_wdata_i[CountW-1:0];
        CFG_MAX_FAILURE:    max_fail_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // event decode: next automaton state and result word
  always_comb begin
    st       = (state_q > ST_OPENED) ? ST_INITIAL : state_q;
    state_d  = st;
    retry_d  = retry_q;
    cnt_d    = cnt_q;
    run_d    = run_q;
    req_id_d = req_id_q;
    res_d    = '0;
    do_irc   = 1'b0;
    do_str   = 1'b0;
    do_rcr   = 1'b0;
    irc_n    = '0;

    case (in_i.op)
      OP_LOWER_UP: begin
        if (st == ST_INITIAL) begin
          state_d = ST_CLOSED;
        end else if (st == ST_STARTING) begin
          do_irc = 1'b1; irc_n = max_conf_q;
          res_d.emit_conf_request = 1'b1;
          state_d = ST_REQ_SENT;
        end
      end
      OP_LOWER_DOWN: begin
        case (st)
          ST_CLOSED, ST_CLOSING: state_d = ST_INITIAL;
          ST_STOPPED: begin
            res_d.layer_notice = N_STARTED; state_d = ST_STARTING;
          end
          ST_STOPPING, ST_REQ_SENT, ST_ACK_RCVD, ST_ACK_SENT: state_d = ST_STARTING;
          ST_OPENED: begin
            res_d.layer_notice = N_DOWN; state_d = ST_STARTING;
          end
          default: ;
        endcase
      end
      OP_OPEN: begin
        // restart option: lower down then lower up in one step
        case (st)
          ST_INITIAL: begin
            res_d.layer_notice = N_STARTED; state_d = ST_STARTING;
          end
          ST_CLOSING: state_d = ST_CLOSED;
          ST_CLOSED, ST_STOPPING, ST_STOPPED, ST_OPENED: begin
            if (st == ST_STOPPED) res_d.layer_notice = N_STARTED;
            if (st == ST_OPENED) res_d.layer_notice = N_DOWN;
            do_irc = 1'b1; irc_n = max_conf_q;
            res_d.emit_conf_request = 1'b1;
            state_d = ST_REQ_SENT;
          end
          default: ;
        endcase
      end
      OP_CLOSE: begin
        case (st)
          ST_STARTING: begin
            res_d.layer_notice = N_FINISHED; state_d = ST_INITIAL;
          end
          ST_STOPPED:  state_d = ST_CLOSED;
          ST_STOPPING: state_d = ST_CLOSING;
          ST_OPENED, ST_REQ_SENT, ST_ACK_RCVD, ST_ACK_SENT: begin
            if (st == ST_OPENED) res_d.layer_notice = N_DOWN;
            do_irc = 1'b1; irc_n = max_term_q;
            do_str = 1'b1;
            state_d = ST_CLOSING;
          end
          default: ;
        endcase
      end
      OP_RCR_GOOD, OP_RCR_NAK, OP_RCR_REJ: begin
        case (st)
          ST_CLOSED: res_d.emit_term_ack = 1'b1;
          ST_STOPPED: begin
            do_irc = 1'b1; irc_n = max_conf_q;
            res_d.emit_conf_request = 1'b1;
            do_rcr = 1'b1;
          end
          ST_REQ_SENT, ST_ACK_SENT, ST_ACK_RCVD: do_rcr = 1'b1;
          ST_OPENED: begin
            res_d.layer_notice = N_DOWN;
            res_d.emit_conf_request = 1'b1;
            do_rcr = 1'b1;
          end
          default: ;
        endcase
        if (do_rcr) begin
          if (in_i.op == OP_RCR_GOOD) begin
            res_d.emit_conf_ack = 1'b1;
            if (st == ST_ACK_RCVD) begin
              res_d.layer_notice = N_UP; state_d = ST_OPENED;
            end else begin
              state_d = ST_ACK_SENT;
            end
          end else begin
            if (in_i.op == OP_RCR_REJ) res_d.emit_conf_reject = 1'b1;
            else res_d.emit_conf_nak = 1'b1;
            if (st != ST_ACK_RCVD) state_d = ST_REQ_SENT;
          end
        end
      end
      OP_RCA: begin
        case (st)
          ST_CLOSED, ST_STOPPED: res_d.emit_term_ack = 1'b1;
          ST_REQ_SENT: begin
            do_irc = 1'b1; irc_n = max_conf_q; state_d = ST_ACK_RCVD;
          end
          ST_ACK_RCVD: begin
            res_d.emit_conf_request = 1'b1; state_d = ST_REQ_SENT;
          end
          ST_ACK_SENT: begin
            do_irc = 1'b1; irc_n = max_conf_q;
            res_d.layer_notice = N_UP; state_d = ST_OPENED;
          end
          ST_OPENED: begin
            res_d.layer_notice = N_DOWN;
            res_d.emit_conf_request = 1'b1; state_d = ST_REQ_SENT;
          end
          default: ;
        endcase
      end
      OP_RCN: begin
        case (st)
          ST_CLOSED, ST_STOPPED: res_d.emit_term_ack = 1'b1;
          ST_REQ_SENT: begin
            do_irc = 1'b1; irc_n = max_fail_q;
            res_d.emit_conf_request = 1'b1;
          end
          ST_ACK_RCVD: begin
            res_d.emit_conf_request = 1'b1; state_d = ST_REQ_SENT;
          end
          ST_ACK_SENT: begin
            do_irc = 1'b1; irc_n = max_conf_q;
            res_d.emit_conf_request = 1'b1;
          end
          ST_OPENED: begin
            res_d.layer_notice = N_DOWN;
            res_d.emit_conf_request = 1'b1; state_d = ST_REQ_SENT;
          end
          default: ;
        endcase
      end
      OP_RTR: begin
        case (st)
          ST_INITIAL, ST_STARTING: ;
          ST_OPENED: begin
            res_d.layer_notice = N_DOWN;
            res_d.emit_term_ack = 1'b1;
            do_irc = 1'b1; irc_n = '0;
            state_d = ST_STOPPING;
          end
          ST_REQ_SENT, ST_ACK_RCVD, ST_ACK_SENT: begin
            res_d.emit_term_ack = 1'b1; state_d = ST_REQ_SENT;
          end
          default: res_d.emit_term_ack = 1'b1;
        endcase
      end
      OP_RTA: begin
        case (st)
          ST_CLOSING: begin
            res_d.layer_notice = N_FINISHED; state_d = ST_CLOSED;
          end
          ST_STOPPING: begin
            res_d.layer_notice = N_FINISHED; state_d = ST_STOPPED;
          end
          ST_ACK_RCVD: state_d = ST_REQ_SENT;
          ST_OPENED: begin
            res_d.layer_notice = N_DOWN;
            res_d.emit_conf_request = 1'b1; state_d = ST_REQ_SENT;
          end
          default: ;
        endcase
      end
      OP_RUC: res_d.emit_conf_reject = 1'b1;
      OP_RXJ_PERM: begin
        if (st == ST_ACK_RCVD) state_d = ST_REQ_SENT;
      end
      OP_RXJ_BAD: begin
        case (st)
          ST_OPENED: begin
            res_d.layer_notice = N_DOWN;
            do_irc = 1'b1; irc_n = max_term_q;
            do_str = 1'b1;
            state_d = ST_STOPPING;
          end
          ST_CLOSED, ST_CLOSING: begin
            res_d.layer_notice = N_FINISHED; state_d = ST_CLOSED;
          end
          ST_STOPPED, ST_STOPPING, ST_REQ_SENT, ST_ACK_RCVD, ST_ACK_SENT: begin
            res_d.layer_notice = N_FINISHED; state_d = ST_STOPPED;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        // restart timer: count down, then retry or give up
        if (run_q) begin
          if (cnt_q > PeriodW'(1)) begin
            cnt_d = cnt_q - PeriodW'(1);
          end else if (retry_q != '0) begin
            case (st)
              ST_CLOSING, ST_STOPPING: do_str = 1'b1;
              ST_ACK_RCVD: begin
                state_d = ST_REQ_SENT; res_d.emit_conf_request = 1'b1;
              end
              ST_REQ_SENT, ST_ACK_SENT: res_d.emit_conf_request = 1'b1;
              default: ;
            endcase
            retry_d = retry_q - CountW'(1);
            cnt_d   = period_q;
          end else begin
            case (st)
              ST_CLOSING: begin
                res_d.layer_notice = N_FINISHED; state_d = ST_CLOSED;
              end
              ST_STOPPING, ST_ACK_RCVD, ST_REQ_SENT, ST_ACK_SENT: begin
                res_d.layer_notice = N_FINISHED; state_d = ST_STOPPED;
              end
              default: ;
            endcase
            run_d = 1'b0;
            cnt_d = '0;
          end
        end
      end
      default: ;
    endcase

    // restart counter load
    if (do_irc) begin
      retry_d = irc_n;
      cnt_d   = period_q;
      run_d   = 1'b1;
    end
    // terminate request with the next id
    if (do_str) begin
      req_id_d                = req_id_q + IdW'(1);
      res_d.emit_term_request = 1'b1;
      res_d.term_request_id   = req_id_d;
    end
    if (res_d.emit_term_ack) res_d.term_ack_id = in_i.received_id;
    res_d.new_state = state_d;
  end

  // automaton registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INITIAL;
      retry_q  <= '0;
      cnt_q    <= '0;
      run_q    <= 1'b0;
      req_id_q <= '0;
    end else if (accept) begin
      state_q  <= state_d;
      retry_q  <= retry_d;
      cnt_q    <= cnt_d;
      run_q    <= run_d;
      req_id_q <= req_id_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (accept) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.new_state         = res_q.new_state;
  assign out_o.layer_notice      = res_q.layer_notice;
  assign out_o.emit_conf_request = res_q.emit_conf_request;
  assign out_o.emit_conf_ack     = res_q.emit_conf_ack;
  assign out_o.emit_conf_nak     = res_q.emit_conf_nak;
  assign out_o.emit_conf_reject  = res_q.emit_conf_reject;
  assign out_o.emit_term_request = res_q.emit_term_request;
  assign out_o.emit_term_ack     = res_q.emit_term_ack;
  assign out_o.term_request_id   = res_q.term_request_id;
  assign out_o.term_ack_id       = res_q.term_ack_id;

  // a stopped timer holds no pending count
  assert property (@(posedge clk_i) disable iff (!rst_ni) !run_q |-> cnt_q == '0)
    else $error("restart timer stopped with nonzero count");

  // a tick with the timer stopped leaves the automaton alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.op == OP_TICK && !run_q) |=> state_q == $past(state_q))
    else $error("tick changed state with timer stopped");

  // terminate request carries the id just stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_d.emit_term_request) |=> res_q.term_request_id == req_id_q)
    else $error("terminate request id does not match stored id");

  // layer up only on entering opened
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.layer_notice == N_UP) |-> res_q.new_state == ST_OPENED)
    else $error("layer up reported outside opened");

  // reported state is the stored state after the last event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> res_q.new_state == state_q)
    else $error("result state differs from automaton state");

endmodule
